// File: hw/rtl/lsac_pkg.sv
// Package: types and constants for the LRU set-associative cache tag store
package lsac_pkg;
  localparam int MaxSetBits = 8;
  localparam int MaxWays    = 8;
  localparam int NumSets    = 1 << MaxSetBits;
  localparam int WayW       = $clog2(MaxWays);
  localparam int SetW       = MaxSetBits;
  localparam int TagW       = 63;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 6;

  localparam logic [1:0] OpFetch  = 2'd0;
  localparam logic [1:0] OpLoad   = 2'd1;
  localparam logic [1:0] OpStore  = 2'd2;
  localparam logic [1:0] OpModify = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWays      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic        last_of_run;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_t;

  // one set row: valid, rank and tag per way
  typedef struct packed {
    logic [MaxWays-1:0]           valid;
    logic [MaxWays-1:0][WayW-1:0] rank;
    logic [MaxWays-1:0][TagW-1:0] tag;
  } row_t;
endpackage

// File: hw/rtl/lsac_stream_if.sv
// Interface: valid/ready channel with a generic payload
interface lsac_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/lru_set_assoc_cache_tags.sv
// An accepted access passes the row read, lookup and output register to its result.
// No new access is taken until the read-modify-write of one set row in the single-port
// row memory is through; a modify gives two lookups and results, a fetch none.
// A result held by the receiver stalls the input until it is taken.
// Reset and each write to a defined config register clear all 256 set rows, one row
// per cycle while cfg_we is low, and no transaction is accepted. Reset zeroes totals.
module lru_set_assoc_cache_tags (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lsac_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lsac_pkg::CfgDataW-1:0] cfg_data,
  lsac_stream_if.sink                   in_ch,
  lsac_stream_if.source                 out_ch
);
  import lsac_pkg::*;

  row_t mem [NumSets];
  row_t rd_r;
  state_t st_r, st_nxt;
  logic [SetW-1:0] clr_r;
  logic [3:0] sb_r;
  logic [5:0] bb_r;
  logic [3:0] wy_r;
  logic second_r;
  logic [SetW-1:0] set_r;
  logic [TagW-1:0] tag_r;
  logic [31:0] hc_r, mc_r, ec_r;
  out_t ob_r;

  logic [3:0] sb_e, n_e;
  logic [6:0] tsh;
  logic [SetW-1:0] sidx;
  logic [TagW-1:0] tag;
  logic [63:0] sh;

  always_comb begin
    sb_e = (sb_r > 4'(MaxSetBits)) ? 4'(MaxSetBits) : sb_r;
    n_e  = (wy_r == 4'd0) ? 4'd1 : ((wy_r > 4'(MaxWays)) ? 4'(MaxWays) : wy_r);
    tsh  = 7'(sb_e) + 7'(bb_r);
    sh   = in_ch.data.address >> bb_r;
    sidx = SetW'(sh & ((64'd1 << sb_e) - 64'd1));
    sh   = in_ch.data.address >> tsh[5:0];
    tag  = tsh[6] ? '0 : sh[TagW-1:0];
  end

  // lookup
  logic hit, ev;
  logic [WayW-1:0] vic, hw, lw;
  logic [WayW-1:0] rv;
  row_t wr;
  always_comb begin
    hit = 1'b0; hw = '0; lw = '0;
    for (int w = MaxWays-1; w >= 0; w--) begin
      if (4'(w) < n_e && rd_r.valid[w] && rd_r.tag[w] == tag_r) begin
        hit = 1'b1; hw = WayW'(w);
      end
      if (4'(w) < n_e && 4'(rd_r.rank[w]) == n_e - 4'd1) lw = WayW'(w);
    end
    vic = hit ? hw : lw;
    ev  = !hit && rd_r.valid[vic];
    rv  = rd_r.rank[vic];
    wr  = rd_r;
    for (int w = 0; w < MaxWays; w++) begin
      if (4'(w) < n_e && rd_r.rank[w] < rv) wr.rank[w] = rd_r.rank[w] + 1'b1;
    end
    wr.rank[vic]  = '0;
    wr.valid[vic] = 1'b1;
    wr.tag[vic]   = tag_r;
  end

  function automatic logic [31:0] sat(input logic [31:0] v, input logic en);
    return (en && v != '1) ? v + 32'd1 : v;
  endfunction

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // only writes to a defined register clear the store
  logic cfg_wr;
  assign cfg_wr = cfg_we && (cfg_index == CfgSetBits || cfg_index == CfgBlockBits ||
                             cfg_index == CfgWays);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == '1) st_nxt = ST_IDLE;
      ST_IDLE:  if (acc && in_ch.data.operation != OpFetch) st_nxt = ST_LOOK;
      ST_LOOK:  st_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) st_nxt = second_r ? ST_LOOK : ST_IDLE;
      end
      default:  st_nxt = ST_IDLE;
    endcase
    if (cfg_wr) st_nxt = ST_CLEAR;
  end

  assign in_ch.ready  = (st_r == ST_IDLE) && !cfg_we;
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.data  = ob_r;

  row_t rst_row;
  always_comb begin
    rst_row = '0;
    for (int w = 0; w < MaxWays; w++) rst_row.rank[w] = WayW'(w);
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) mem[clr_r] <= rst_row;
    else if (st_r == ST_LOOK) mem[set_r] <= wr;
    if (st_r == ST_IDLE) rd_r <= mem[sidx];
    else if (st_r == ST_LOOK) rd_r <= wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; sb_r <= 4'd1; bb_r <= 6'd1; wy_r <= 4'd1;
      hc_r <= '0; mc_r <= '0; ec_r <= '0; second_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_wr) clr_r <= '0;
        unique case (cfg_index)
          CfgSetBits:   sb_r <= cfg_data[3:0];
          CfgBlockBits: bb_r <= cfg_data;
          CfgWays:      wy_r <= cfg_data[3:0];
          default: ;
        endcase
      end else if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (acc) begin
        second_r <= in_ch.data.operation == OpModify;
        set_r <= sidx; tag_r <= tag;
      end
      if (st_r == ST_OUT && out_ch.ready) second_r <= 1'b0;
      if (st_r == ST_LOOK) begin
        hc_r <= sat(hc_r, hit); mc_r <= sat(mc_r, !hit); ec_r <= sat(ec_r, ev);
        ob_r.hit <= hit; ob_r.evicted <= ev; ob_r.last_of_run <= !second_r;
        ob_r.hit_total <= sat(hc_r, hit); ob_r.miss_total <= sat(mc_r, !hit);
        ob_r.eviction_total <= sat(ec_r, ev);
      end
    end
  end
endmodule
